// ----- rtl/dpar_pkg.sv -----
// ----------------------------------------------------------------------------
// dpar_pkg
// Types, register indexes and the error-to-step mapping shared by the
// dual peak-to-peak amplitude regulator.
// ----------------------------------------------------------------------------
package dpar_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned CFG_IDX_W = 4;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_CH0 = 4'd0,
    REG_TARGET_CH1 = 4'd1,
    REG_ENABLE     = 4'd2,
    REG_AMP_LIMIT  = 4'd3
  } reg_idx_t;

  localparam data_t AMP_LIMIT_RESET = 16'd255;
  localparam data_t MIN_INIT        = 16'hFFFF;

  localparam logic [DATA_W:0] THR_BIG  = 17'd200;
  localparam logic [DATA_W:0] THR_MID  = 17'd100;
  localparam logic [DATA_W:0] THR_SML  = 17'd50;
  localparam logic [DATA_W:0] THR_TINY = 17'd20;

  localparam step_t STEP_BIG  = 4'd10;
  localparam step_t STEP_MID  = 4'd5;
  localparam step_t STEP_SML  = 4'd2;
  localparam step_t STEP_TINY = 4'd1;
  localparam step_t STEP_NONE = 4'd0;

  typedef struct packed {
    logic track;
    logic clear;
    logic capture;
    logic s2_load;
    logic amp_load;
  } lane_ctrl_t;

  typedef struct packed {
    data_t p2p;
    data_t amp;
    logic  changed;
  } lane_res_t;

  function automatic step_t err_step(input logic [DATA_W:0] mag);
    step_t st;
    if (mag > THR_BIG) begin
      st = STEP_BIG;
    end else if (mag > THR_MID) begin
      st = STEP_MID;
    end else if (mag > THR_SML) begin
      st = STEP_SML;
    end else if (mag > THR_TINY) begin
      st = STEP_TINY;
    end else begin
      st = STEP_NONE;
    end
    return st;
  endfunction

endpackage

// ----- rtl/dual_p2p_amplitude_regulator_top.sv -----
// ----------------------------------------------------------------------------
// dual_p2p_amplitude_regulator_top
// Tracks the peak-to-peak swing of two ADC channels per chunk and steps each
// channel's drive amplitude towards its target.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    sample_ch0, sample_ch1, chunk_end
//   out      output     out_valid / out_ready  p2p, amp and changed per channel
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample pair is accepted every cycle while in_ready is high. After its
// chunk-end pair is accepted, a result is held in turn by the capture, step
// and output registers.
// Reset is synchronous; it clears tracking, amplitudes and registers.
// A stalled result holds in the output register; up to three results queue
// in the pipeline before in_ready falls. cfg_ready is always high.
// ----------------------------------------------------------------------------
module dual_p2p_amplitude_regulator_top #(
  parameter int unsigned MAX_PAIRS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dpar_pkg::data_t               in_sample_ch0,
  input  dpar_pkg::data_t               in_sample_ch1,
  input  logic                          in_chunk_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dpar_pkg::data_t               out_p2p_ch0,
  output dpar_pkg::data_t               out_p2p_ch1,
  output dpar_pkg::data_t               out_amp_ch0,
  output dpar_pkg::data_t               out_amp_ch1,
  output logic                          out_changed_ch0,
  output logic                          out_changed_ch1,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  dpar_pkg::data_t               cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);

  dpar_pkg::data_t target_ch0_r, target_ch1_r, amp_limit_r;
  logic            enable_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic             in_fire, room, s2_free, out_free;
  dpar_pkg::lane_ctrl_t ctrl;
  dpar_pkg::lane_res_t  res_ch0, res_ch1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_ch0_r <= '0;
      target_ch1_r <= '0;
      enable_r     <= 1'b0;
      amp_limit_r  <= dpar_pkg::AMP_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dpar_pkg::REG_TARGET_CH0: target_ch0_r <= cfg_data;
        dpar_pkg::REG_TARGET_CH1: target_ch1_r <= cfg_data;
        dpar_pkg::REG_ENABLE:     enable_r     <= cfg_data[0];
        dpar_pkg::REG_AMP_LIMIT:  amp_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_free  = ~s2_v_r | out_free;
  assign in_ready = ~s1_v_r | s2_free;
  assign in_fire  = in_valid & in_ready;
  assign room     = (cnt_r < CNT_W'(MAX_PAIRS));

  always_comb begin
    ctrl.track    = in_fire & room;
    ctrl.clear    = in_fire & in_chunk_end;
    ctrl.capture  = in_fire & in_chunk_end & enable_r;
    ctrl.s2_load  = s1_v_r & s2_free;
    ctrl.amp_load = s2_v_r & out_free;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.track) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    s1_v_nxt = s1_v_r;
    if (ctrl.capture) begin
      s1_v_nxt = 1'b1;
    end else if (ctrl.s2_load) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (ctrl.s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (ctrl.amp_load) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  dpar_lane u_lane_ch0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sample    (in_sample_ch0),
    .target    (target_ch0_r),
    .amp_limit (amp_limit_r),
    .res       (res_ch0)
  );

  dpar_lane u_lane_ch1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sample    (in_sample_ch1),
    .target    (target_ch1_r),
    .amp_limit (amp_limit_r),
    .res       (res_ch1)
  );

  dpar_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (ctrl.amp_load),
    .res_ch0         (res_ch0),
    .res_ch1         (res_ch1),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_p2p_ch0     (out_p2p_ch0),
    .out_p2p_ch1     (out_p2p_ch1),
    .out_amp_ch0     (out_amp_ch0),
    .out_amp_ch1     (out_amp_ch1),
    .out_changed_ch0 (out_changed_ch0),
    .out_changed_ch1 (out_changed_ch1)
  );

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PAIRS))
    else $error("pair count beyond its limit");

  a_chunk_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chunk_end) |=> (cnt_r == '0))
    else $error("tracking not cleared after chunk end");

  a_capture_en: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chunk_end) |=> (s1_v_r == $past(enable_r)))
    else $error("chunk end captured against the enable setting");

endmodule

// ----- rtl/dpar_lane.sv -----
// ----------------------------------------------------------------------------
// dpar_lane
// One channel lane: minimum and maximum tracking over a chunk, the step
// calculation and the amplitude update.
// ----------------------------------------------------------------------------
module dpar_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  dpar_pkg::lane_ctrl_t ctrl,
  input  dpar_pkg::data_t     sample,
  input  dpar_pkg::data_t     target,
  input  dpar_pkg::data_t     amp_limit,
  output dpar_pkg::lane_res_t res
);

  dpar_pkg::data_t max_r, max_nxt, min_r, min_nxt;
  dpar_pkg::data_t max_upd, min_upd;
  dpar_pkg::data_t s1_max_r, s1_min_r;
  dpar_pkg::data_t s2_p2p_r;
  dpar_pkg::step_t s2_step_r;
  logic            s2_pos_r;
  dpar_pkg::data_t amp_r, amp_nxt;

  dpar_pkg::data_t             p2p;
  logic signed [dpar_pkg::DATA_W:0] err;
  logic [dpar_pkg::DATA_W:0]   mag;
  logic [dpar_pkg::DATA_W:0]   amp_sum;
  dpar_pkg::data_t             amp_new;

  always_comb begin
    max_upd = max_r;
    min_upd = min_r;
    if (ctrl.track) begin
      if (sample > max_r) max_upd = sample;
      if (sample < min_r) min_upd = sample;
    end
    if (ctrl.clear) begin
      max_nxt = '0;
      min_nxt = dpar_pkg::MIN_INIT;
    end else begin
      max_nxt = max_upd;
      min_nxt = min_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      min_r <= dpar_pkg::MIN_INIT;
    end else begin
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      s1_max_r <= max_upd;
      s1_min_r <= min_upd;
    end
  end

  always_comb begin
    p2p = (s1_max_r > s1_min_r) ? (s1_max_r - s1_min_r) : '0;
    err = $signed({1'b0, p2p}) - $signed({1'b0, target});
    mag = err[dpar_pkg::DATA_W] ? (dpar_pkg::DATA_W+1)'(-err) : $unsigned(err);
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      s2_p2p_r  <= p2p;
      s2_step_r <= dpar_pkg::err_step(mag);
      s2_pos_r  <= ~err[dpar_pkg::DATA_W];
    end
  end

  always_comb begin
    amp_sum = {1'b0, amp_r} + {{(dpar_pkg::DATA_W+1-dpar_pkg::STEP_W){1'b0}}, s2_step_r};
    amp_new = amp_r;
    if (s2_step_r != dpar_pkg::STEP_NONE) begin
      if (s2_pos_r) begin
        if (amp_r > dpar_pkg::DATA_W'(s2_step_r)) begin
          amp_new = amp_r - dpar_pkg::DATA_W'(s2_step_r);
        end
      end else if (amp_sum < {1'b0, amp_limit}) begin
        amp_new = amp_sum[dpar_pkg::DATA_W-1:0];
      end
    end
    amp_nxt = ctrl.amp_load ? amp_new : amp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= '0;
    end else begin
      amp_r <= amp_nxt;
    end
  end

  assign res.p2p     = s2_p2p_r;
  assign res.amp     = amp_new;
  assign res.changed = (s2_step_r != dpar_pkg::STEP_NONE);

endmodule

// ----- rtl/dpar_merge.sv -----
// ----------------------------------------------------------------------------
// dpar_merge
// Output stage: joins the results of both lanes into one registered result
// request and holds it until it is taken.
// ----------------------------------------------------------------------------
module dpar_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dpar_pkg::lane_res_t res_ch0,
  input  dpar_pkg::lane_res_t res_ch1,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output dpar_pkg::data_t     out_p2p_ch0,
  output dpar_pkg::data_t     out_p2p_ch1,
  output dpar_pkg::data_t     out_amp_ch0,
  output dpar_pkg::data_t     out_amp_ch1,
  output logic                out_changed_ch0,
  output logic                out_changed_ch1
);

  logic                valid_r, valid_nxt;
  dpar_pkg::lane_res_t ch0_r, ch1_r;

  assign free = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch0_r <= res_ch0;
      ch1_r <= res_ch1;
    end
  end

  assign out_valid       = valid_r;
  assign out_p2p_ch0     = ch0_r.p2p;
  assign out_p2p_ch1     = ch1_r.p2p;
  assign out_amp_ch0     = ch0_r.amp;
  assign out_amp_ch1     = ch1_r.amp;
  assign out_changed_ch0 = ch0_r.changed;
  assign out_changed_ch1 = ch1_r.changed;

endmodule
